/* src/mtpc_pkg.sv */
// Shared constants, codes and types of the musical tick position converter.
`default_nettype none
package mtpc_pkg;

   localparam int TICKS_PER_QUARTER = 960;
   localparam int WHOLE_TICKS = 4 * TICKS_PER_QUARTER;

   localparam int CMD_W = 3;
   localparam int TICK_W = 32;
   localparam int BAR_IN_W = 16;
   localparam int BEAT_IN_W = 6;
   localparam int OFF_W = 12;
   localparam int RES_W = 33;
   localparam int BAR_OUT_W = 32;
   localparam int BEAT_OUT_W = 5;
   localparam int NUM_W = 6;
   localparam int DEN_W = 7;
   localparam int IDX_W = 2;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 88;

   localparam int NUM_MAX = (1 << NUM_W) - 1;
   localparam int LEN_W = $clog2(NUM_MAX * WHOLE_TICKS + 1);
   localparam int BEAT_LEN_W = $clog2(WHOLE_TICKS + 1);
   localparam int GRID_LEN_W = $clog2(TICKS_PER_QUARTER + 1);
   localparam int BEAT_OUT_MAX = (1 << BEAT_OUT_W) - 1;
   localparam int OFF_MAX = (1 << OFF_W) - 1;
   localparam int SUM_W = RES_W + 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_TO_POS = 3'd0,
      CMD_TO_TICK = 3'd1,
      CMD_SNAP_BAR = 3'd2,
      CMD_SNAP_BEAT = 3'd3,
      CMD_SNAP_GRID = 3'd4
   } cmd_type;

   typedef enum logic [IDX_W-1:0] {
      REG_BEATS_PER_BAR = 2'd0,
      REG_BEAT_NOTE_VALUE = 2'd1,
      REG_GRID_DIVISION = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [LEN_W-1:0] bar_len;
      logic [BEAT_LEN_W-1:0] beat_len;
   } len_type;

   typedef struct packed {
      cmd_type cmd;
      logic [TICK_W-1:0] tick;
      logic [BAR_IN_W-1:0] bar;
      logic [BEAT_IN_W-1:0] beat;
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] divisor;
   } entry_type;

endpackage
`default_nettype wire

/* src/mtpc_front.sv */
// Front end: configuration registers, length computation and request classification.
`default_nettype none
module mtpc_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [mtpc_pkg::IDX_W-1:0] csr_index,
   input wire logic [mtpc_pkg::CSR_DATA_W-1:0] csr_data,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [mtpc_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic [mtpc_pkg::CMD_W-1:0] req_tuser,
   output logic push,
   output mtpc_pkg::entry_type push_entry,
   input wire logic full,
   output mtpc_pkg::len_type lens
);
   import mtpc_pkg::*;

   localparam int CNT_W = $clog2(LEN_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] grid_ff, grid_in;
   logic busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff [3];
   logic [LEN_W-1:0] sh_ff [3];
   logic [DEN_W-1:0] div_ff [3];
   logic [DEN_W-1:0] rem_in [3];
   logic [LEN_W-1:0] sh_in [3];
   logic [LEN_W-1:0] bar_len_ff;
   logic [BEAT_LEN_W-1:0] beat_len_ff;
   logic [GRID_LEN_W-1:0] grid_len_ff;
   logic csr_write;
   cmd_type cmd;

   function automatic logic [DEN_W-1:0] at_least_one(input logic [DEN_W-1:0] v);
      return (v == '0) ? DEN_W'(1) : v;
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      grid_in = grid_ff;
      if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_BEATS_PER_BAR: num_in = csr_data[NUM_W-1:0];
            REG_BEAT_NOTE_VALUE: den_in = csr_data[DEN_W-1:0];
            REG_GRID_DIVISION: grid_in = csr_data[DEN_W-1:0];
            default: num_in = num_ff;
         endcase
      end
   end

   always_comb begin
      logic [DEN_W:0] t;
      t = '0;
      for (int k = 0; k < 3; k++) begin
         t = {rem_ff[k], sh_ff[k][LEN_W-1]};
         if (t >= {1'b0, div_ff[k]}) begin
            rem_in[k] = DEN_W'(t - {1'b0, div_ff[k]});
            sh_in[k] = {sh_ff[k][LEN_W-2:0], 1'b1};
         end else begin
            rem_in[k] = t[DEN_W-1:0];
            sh_in[k] = {sh_ff[k][LEN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= NUM_W'(4);
         den_ff <= DEN_W'(4);
         grid_ff <= DEN_W'(1);
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         bar_len_ff <= LEN_W'(WHOLE_TICKS);
         beat_len_ff <= BEAT_LEN_W'(TICKS_PER_QUARTER);
         grid_len_ff <= GRID_LEN_W'(TICKS_PER_QUARTER);
      end else begin
         num_ff <= num_in;
         den_ff <= den_in;
         grid_ff <= grid_in;
         if (csr_write) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff[0] <= '0;
            rem_ff[1] <= '0;
            rem_ff[2] <= '0;
            sh_ff[0] <= LEN_W'((num_in == '0 ? 1 : int'(num_in)) * WHOLE_TICKS);
            sh_ff[1] <= LEN_W'(WHOLE_TICKS);
            sh_ff[2] <= LEN_W'(TICKS_PER_QUARTER);
            div_ff[0] <= at_least_one(den_in);
            div_ff[1] <= at_least_one(den_in);
            div_ff[2] <= at_least_one(grid_in);
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            sh_ff <= sh_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(LEN_W - 1)) begin
               busy_ff <= 1'b0;
               bar_len_ff <= (sh_in[0] == '0) ? LEN_W'(1) : sh_in[0];
               beat_len_ff <= (sh_in[1] == '0) ? BEAT_LEN_W'(1)
                                               : sh_in[1][BEAT_LEN_W-1:0];
               grid_len_ff <= (sh_in[2] == '0) ? GRID_LEN_W'(1)
                                               : sh_in[2][GRID_LEN_W-1:0];
            end
         end
      end
   end

   assign req_tready = !busy_ff && !full;
   assign push = req_tvalid && req_tready;
   assign cmd = cmd_type'(req_tuser);

   always_comb begin
      push_entry.cmd = cmd;
      push_entry.tick = req_tdata[31:0];
      push_entry.bar = req_tdata[47:32];
      push_entry.beat = req_tdata[53:48];
      push_entry.off = req_tdata[65:54];
      case (cmd)
         CMD_SNAP_BEAT: push_entry.divisor = LEN_W'(beat_len_ff);
         CMD_SNAP_GRID: push_entry.divisor = LEN_W'(grid_len_ff);
         default: push_entry.divisor = bar_len_ff;
      endcase
   end

   assign lens.bar_len = bar_len_ff;
   assign lens.beat_len = beat_len_ff;

   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> busy_ff) else $error("length computation did not start");
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !push) else $error("request taken while lengths settle");

endmodule
`default_nettype wire

/* src/mtpc_queue.sv */
// Short queue between the front end and the divider pipeline.
`default_nettype none
module mtpc_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire mtpc_pkg::entry_type push_entry,
   input wire logic pop,
   output mtpc_pkg::entry_type head,
   output logic full,
   output logic empty
);
   import mtpc_pkg::*;

   entry_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0] count_ff;
   logic do_pop;

   assign full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(do_pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("transfer into a full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

/* src/mtpc_back.sv */
// Back end: pipelined dividers, snapping, position sum and the result register.
`default_nettype none
module mtpc_back (
   input wire logic clock,
   input wire logic reset,
   input wire mtpc_pkg::entry_type head,
   input wire logic empty,
   output logic pop,
   input wire mtpc_pkg::len_type lens,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [mtpc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mtpc_pkg::*;

   localparam int LAST = TICK_W + LEN_W;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
      logic [TICK_W-1:0] tick;
      logic [LEN_W-1:0] divisor;
      logic [LEN_W-1:0] rem;
      logic [TICK_W-1:0] sh;
      logic [BEAT_LEN_W-1:0] rem2;
      logic [LEN_W-1:0] sh2;
      logic [BAR_IN_W+LEN_W-1:0] prod_bar;
      logic [BEAT_IN_W+BEAT_LEN_W-1:0] prod_beat;
      logic [OFF_W-1:0] off;
   } pipe_type;

   typedef struct packed {
      logic valid;
      logic [RES_W-1:0] result;
      logic [BAR_OUT_W-1:0] bar;
      logic [BEAT_OUT_W-1:0] beat;
      logic [OFF_W-1:0] off;
   } rsp_type;

   pipe_type pipe_ff [LAST+1];
   pipe_type pipe_in [LAST+1];
   rsp_type out_ff, out_in;
   logic en;

   assign en = !out_ff.valid || rsp_tready;
   assign pop = en;

   always_comb begin
      logic [LEN_W:0] t_main;
      logic [BEAT_LEN_W:0] t_beat;
      t_main = '0;
      t_beat = '0;
      pipe_in[0].valid = !empty;
      pipe_in[0].cmd = head.cmd;
      pipe_in[0].tick = head.tick;
      pipe_in[0].divisor = head.divisor;
      pipe_in[0].rem = '0;
      pipe_in[0].sh = head.tick;
      pipe_in[0].rem2 = '0;
      pipe_in[0].sh2 = '0;
      pipe_in[0].prod_bar = (BAR_IN_W + LEN_W)'(head.bar)
                          * (BAR_IN_W + LEN_W)'(lens.bar_len);
      pipe_in[0].prod_beat = (BEAT_IN_W + BEAT_LEN_W)'(head.beat)
                           * (BEAT_IN_W + BEAT_LEN_W)'(lens.beat_len);
      pipe_in[0].off = head.off;
      for (int i = 1; i <= LAST; i++) begin
         pipe_in[i] = pipe_ff[i-1];
         if (i <= TICK_W) begin
            t_main = {pipe_ff[i-1].rem, pipe_ff[i-1].sh[TICK_W-1]};
            if (t_main >= {1'b0, pipe_ff[i-1].divisor}) begin
               pipe_in[i].rem = LEN_W'(t_main - {1'b0, pipe_ff[i-1].divisor});
               pipe_in[i].sh = {pipe_ff[i-1].sh[TICK_W-2:0], 1'b1};
            end else begin
               pipe_in[i].rem = t_main[LEN_W-1:0];
               pipe_in[i].sh = {pipe_ff[i-1].sh[TICK_W-2:0], 1'b0};
            end
            if (i == TICK_W) begin
               pipe_in[i].sh2 = pipe_in[i].rem;
               pipe_in[i].rem2 = '0;
            end
         end else begin
            t_beat = {pipe_ff[i-1].rem2, pipe_ff[i-1].sh2[LEN_W-1]};
            if (t_beat >= {1'b0, lens.beat_len}) begin
               pipe_in[i].rem2 = BEAT_LEN_W'(t_beat - {1'b0, lens.beat_len});
               pipe_in[i].sh2 = {pipe_ff[i-1].sh2[LEN_W-2:0], 1'b1};
            end else begin
               pipe_in[i].rem2 = t_beat[BEAT_LEN_W-1:0];
               pipe_in[i].sh2 = {pipe_ff[i-1].sh2[LEN_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   always_comb begin
      logic [RES_W-1:0] tick_w;
      logic [RES_W-1:0] rem_w;
      logic [RES_W-1:0] len_w;
      logic [SUM_W-1:0] sum;
      logic [31:0] q2_w;
      logic [31:0] r2_w;
      tick_w = RES_W'(pipe_ff[LAST].tick);
      rem_w = RES_W'(pipe_ff[LAST].rem);
      len_w = RES_W'(pipe_ff[LAST].divisor);
      sum = SUM_W'(pipe_ff[LAST].prod_bar) + SUM_W'(pipe_ff[LAST].prod_beat)
          + SUM_W'(pipe_ff[LAST].off);
      q2_w = 32'(pipe_ff[LAST].sh2);
      r2_w = 32'(pipe_ff[LAST].rem2);
      out_in.valid = pipe_ff[LAST].valid;
      out_in.result = '0;
      out_in.bar = '0;
      out_in.beat = '0;
      out_in.off = '0;
      case (pipe_ff[LAST].cmd)
         CMD_TO_POS: begin
            out_in.bar = pipe_ff[LAST].sh;
            out_in.beat = (q2_w > 32'(BEAT_OUT_MAX)) ? BEAT_OUT_W'(BEAT_OUT_MAX)
                                                   : q2_w[BEAT_OUT_W-1:0];
            out_in.off = (r2_w > 32'(OFF_MAX)) ? OFF_W'(OFF_MAX) : r2_w[OFF_W-1:0];
         end
         CMD_TO_TICK: begin
            out_in.result = (|sum[SUM_W-1:RES_W]) ? {RES_W{1'b1}} : sum[RES_W-1:0];
         end
         CMD_SNAP_BAR, CMD_SNAP_BEAT, CMD_SNAP_GRID: begin
            if (rem_w < (len_w >> 1)) begin
               out_in.result = tick_w - rem_w;
            end else begin
               out_in.result = tick_w + (len_w - rem_w);
            end
         end
         default: out_in.result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata = {6'b0, out_ff.off, out_ff.beat, out_ff.bar, out_ff.result};

   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[LAST].valid |-> pipe_ff[LAST].rem < pipe_ff[LAST].divisor)
      else $error("tick remainder not below its length");
   a_rem2_below_beat: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[LAST].valid |-> pipe_ff[LAST].rem2 < lens.beat_len)
      else $error("beat remainder not below beat length");

endmodule
`default_nettype wire

/* src/musical_tick_position_converter.sv */
// Throughput: one request per cycle, set by the one-bit-per-stage divider pipeline, while no
// length recompute or held response (rsp_tvalid high, rsp_tready low) stalls the flow.
// A configuration write recomputes bar, beat and grid lengths, and req_tready is low while it
// does so; configuration transfers are always taken.
// Reset is synchronous: registers return to 4/4 time with one grid line, queue and pipe empty.
`default_nettype none
module musical_tick_position_converter (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [mtpc_pkg::IDX_W-1:0] csr_index,
   input wire logic [mtpc_pkg::CSR_DATA_W-1:0] csr_data,
   input wire logic req_tvalid,
   output logic req_tready,
   // tick_in[31:0], bar_in[47:32], beat_in[53:48], offset_in[65:54], zero fill
   input wire logic [mtpc_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[2:0]
   input wire logic [mtpc_pkg::CMD_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // result_tick[32:0], bar_out[64:33], beat_out[69:65], offset_out[81:70], zero fill
   output logic [mtpc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mtpc_pkg::*;

   logic push;
   logic pop;
   logic full;
   logic empty;
   entry_type push_entry;
   entry_type head;
   len_type lens;

   mtpc_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .push(push),
      .push_entry(push_entry),
      .full(full),
      .lens(lens)
   );

   mtpc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .head(head),
      .full(full),
      .empty(empty)
   );

   mtpc_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .empty(empty),
      .pop(pop),
      .lens(lens),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   a_csr_stalls_req: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !req_tready)
      else $error("request side open while lengths are recomputed");

endmodule
`default_nettype wire
